// ===== sv/tssp_pkg.sv =====
// types and constants shared by the tracker sensor packet parser
`timescale 1ns / 1ps
`default_nettype none

package tssp_pkg;

	localparam logic [2:0] KIND_HEADER = 3'd0;
	localparam logic [2:0] KIND_ACCEL  = 3'd1;
	localparam logic [2:0] KIND_GYRO   = 3'd2;
	localparam logic [2:0] KIND_MAG    = 3'd3;
	localparam logic [2:0] KIND_END    = 3'd4;

	localparam logic [6:0] POS_CMD_HI   = 7'd2;
	localparam logic [6:0] POS_COUNT    = 7'd3;
	localparam logic [6:0] POS_TEMP_HI  = 7'd7;
	localparam logic [6:0] POS_HEADER   = 7'd11;
	localparam logic [6:0] POS_SLOT_LO  = 7'd19;
	localparam logic [6:0] POS_SLOT_HI  = 7'd43;
	localparam logic [6:0] POS_MAG      = 7'd49;
	localparam logic [6:0] POS_MAX      = 7'd127;
	localparam logic [6:0] POS_LEN_A    = 7'd61;
	localparam logic [6:0] POS_LEN_B    = 7'd63;

	localparam logic [7:0] MAX_SAMPLES  = 8'd2;

	localparam int TDATA_W = 136;

	typedef struct packed {
		logic [2:0]         record_kind;
		logic               sample_index;
		logic signed [20:0] axis_x;
		logic signed [20:0] axis_y;
		logic signed [20:0] axis_z;
		logic [15:0]        last_cmd;
		logic [1:0]         sample_count;
		logic signed [15:0] temperature;
		logic [31:0]        timestamp;
		logic               length_ok;
		logic               last;
	} rec_t;

endpackage

`default_nettype wire

// ===== sv/tracker_sensor_packet_parser.sv =====
// tracker sensor report parser: byte stream in, header/sample/mag/end records out
// path: a byte accepted passes the input register, then the result register, where its first record shows
// throughput: one byte per cycle while m_tready is high; a byte that causes two
// records holds the input back while the two-entry result register sends the second
// reset: arst_n clears the byte index, shift register, held header fields
// and all valid flags at once; the first packet starts at index zero
`timescale 1ns / 1ps
`default_nettype none

module tracker_sensor_packet_parser
	import tssp_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [7:0]           s_tdata,  // data_byte
	input  wire logic                 s_tlast,  // end_of_packet
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	// sample_index, axis_x, axis_y, axis_z, last_cmd, sample_count,
	// temperature, timestamp, length_ok, zero fill
	output logic [TDATA_W-1:0]        m_tdata,
	output logic [2:0]                m_tuser,  // record_kind
	output logic                      m_tlast   // last
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        eop_s1;

	logic [6:0]  pos_q;
	logic [63:0] shift_q;
	logic [15:0] cmd_q;
	logic [1:0]  count_q;
	logic [15:0] temp_q;

	logic        valid_s2;
	logic        two_s2;
	rec_t        rec0_s2;
	rec_t        rec1_s2;
	logic        sel_q;

	logic        out_fire;
	logic        s2_free;
	logic        advance;
	logic        in_fire;
	logic [63:0] shift_new;
	logic [6:0]  slot_off;
	logic        is_slot;
	logic        has_main;
	rec_t        main_rec;
	rec_t        end_rec;
	rec_t        out_rec;

	assign out_fire = m_tvalid && m_tready;
	assign s2_free  = !valid_s2 || (out_fire && (sel_q || !two_s2));
	assign advance  = valid_s1 && s2_free;
	assign s_tready = !valid_s1 || advance;
	assign in_fire  = s_tvalid && s_tready;

	assign shift_new = {shift_q[55:0], byte_s1};
	assign slot_off  = pos_q - POS_SLOT_LO;
	assign is_slot   = (pos_q >= POS_SLOT_LO) && (pos_q <= POS_SLOT_HI) &&
		(slot_off[2:0] == 3'd0);

	always_comb begin
		main_rec = '0;
		has_main = 1'b0;
		if (pos_q == POS_HEADER) begin
			has_main              = 1'b1;
			main_rec.record_kind  = KIND_HEADER;
			main_rec.last_cmd     = cmd_q;
			main_rec.sample_count = count_q;
			main_rec.temperature  = temp_q;
			main_rec.timestamp    = {shift_new[7:0], shift_new[15:8],
				shift_new[23:16], shift_new[31:24]};
		end else if (is_slot) begin
			if ({1'b0, slot_off[4]} < count_q) begin
				has_main              = 1'b1;
				main_rec.record_kind  = slot_off[3] ? KIND_GYRO : KIND_ACCEL;
				main_rec.sample_index = slot_off[4];
				main_rec.axis_x       = shift_new[63:43];
				main_rec.axis_y       = shift_new[42:22];
				main_rec.axis_z       = shift_new[21:1];
			end
		end else if (pos_q == POS_MAG) begin
			has_main             = 1'b1;
			main_rec.record_kind = KIND_MAG;
			main_rec.axis_x      = 21'(signed'({shift_new[39:32], shift_new[47:40]}));
			main_rec.axis_y      = 21'(signed'({shift_new[23:16], shift_new[31:24]}));
			main_rec.axis_z      = 21'(signed'({shift_new[7:0], shift_new[15:8]}));
		end
		main_rec.last = !eop_s1;
	end

	always_comb begin
		end_rec             = '0;
		end_rec.record_kind = KIND_END;
		end_rec.length_ok   = (pos_q == POS_LEN_A) || (pos_q == POS_LEN_B);
		end_rec.last        = 1'b1;
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			byte_s1 <= s_tdata;
			eop_s1  <= s_tlast;
		end
	end

	// packet state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			shift_q <= '0;
			cmd_q   <= '0;
			count_q <= '0;
			temp_q  <= '0;
		end else if (advance) begin
			shift_q <= shift_new;
			case (pos_q)
				POS_CMD_HI: begin
					cmd_q <= {shift_new[7:0], shift_new[15:8]};
				end
				POS_COUNT: begin
					count_q <= (byte_s1 > MAX_SAMPLES) ? MAX_SAMPLES[1:0] : byte_s1[1:0];
				end
				POS_TEMP_HI: begin
					temp_q <= {shift_new[7:0], shift_new[15:8]};
				end
				default: begin
				end
			endcase
			if (eop_s1) begin
				pos_q <= '0;
			end else if (pos_q != POS_MAX) begin
				pos_q <= pos_q + 7'd1;
			end
		end
	end

	// result register, up to two records per byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			two_s2   <= 1'b0;
			sel_q    <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= advance && (has_main || eop_s1);
			two_s2   <= has_main && eop_s1;
			sel_q    <= 1'b0;
		end else if (out_fire) begin
			sel_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rec0_s2 <= has_main ? main_rec : end_rec;
			rec1_s2 <= end_rec;
		end
	end

	assign out_rec  = sel_q ? rec1_s2 : rec0_s2;
	assign m_tvalid = valid_s2;
	assign m_tuser  = out_rec.record_kind;
	assign m_tlast  = out_rec.last;
	assign m_tdata  = {5'd0, out_rec.length_ok, out_rec.timestamp, out_rec.temperature,
		out_rec.sample_count, out_rec.last_cmd, out_rec.axis_z, out_rec.axis_y,
		out_rec.axis_x, out_rec.sample_index};

	a_sel_needs_pair: assert property (@(posedge clk) disable iff (!arst_n)
		sel_q |-> (valid_s2 && two_s2))
		else $error("second record selected without a pair");

	a_pair_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && two_s2) |-> (rec1_s2.record_kind == KIND_END))
		else $error("second record of a pair is not an end record");

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == KIND_END)) |-> m_tlast)
		else $error("end record without last");

	a_pos_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && eop_s1) |=> (pos_q == 7'd0))
		else $error("byte index not cleared after end of packet");

endmodule

`default_nettype wire

// ===== tb/tracker_sensor_packet_parser_checker.sv =====
// record predictor and scoreboard for the tracker sensor packet parser
`timescale 1ns / 1ps

module tracker_sensor_packet_parser_checker
	import tssp_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_tvalid,
	input  wire logic               s_tready,
	input  wire logic [7:0]         s_tdata,  // data_byte
	input  wire logic               s_tlast,  // end_of_packet
	input  wire logic               m_tvalid,
	input  wire logic               m_tready,
	// sample_index, axis_x, axis_y, axis_z, last_cmd, sample_count,
	// temperature, timestamp, length_ok, zero fill
	input  wire logic [TDATA_W-1:0] m_tdata,
	input  wire logic [2:0]         m_tuser,  // record_kind
	input  wire logic               m_tlast,  // last
	output int                      fail_count,
	output int                      outstanding,
	output int                      records_checked,
	output int                      good_packets
);

	logic [6:0]  byte_idx;
	logic [63:0] byte_window;
	logic [15:0] cmd_id_hold;
	logic [1:0]  count_hold;
	logic [15:0] temp_hold;
	rec_t        due_records[$];

	// little-endian pair: high byte k bytes back, low byte k+1 bytes back
	function automatic logic [15:0] le16(input logic [63:0] w, input int k);
		return {w[8*k +: 8], w[8*(k+1) +: 8]};
	endfunction

	task automatic parse_byte(input logic [7:0] b, input logic eop);
		rec_t       rec;
		rec_t       found[$];
		logic [6:0] p;
		logic [6:0] rel;
		p = byte_idx;
		rel = p - POS_SLOT_LO;
		byte_window = {byte_window[55:0], b};
		if (p == POS_CMD_HI) begin
			cmd_id_hold = le16(byte_window, 0);
		end else if (p == POS_COUNT) begin
			count_hold = (b > MAX_SAMPLES) ? MAX_SAMPLES[1:0] : b[1:0];
		end else if (p == POS_TEMP_HI) begin
			temp_hold = le16(byte_window, 0);
		end else if (p == POS_HEADER) begin
			rec = '0;
			rec.record_kind = KIND_HEADER;
			rec.last_cmd = cmd_id_hold;
			rec.sample_count = count_hold;
			rec.temperature = temp_hold;
			rec.timestamp = {byte_window[7:0], byte_window[15:8], byte_window[23:16],
				byte_window[31:24]};
			found.push_back(rec);
		end else if (p >= POS_SLOT_LO && p <= POS_SLOT_HI && rel[2:0] == 3'd0) begin
			// rel[4] picks the sample, rel[3] picks accel or gyro
			if ({1'b0, rel[4]} < count_hold) begin
				rec = '0;
				rec.record_kind = rel[3] ? KIND_GYRO : KIND_ACCEL;
				rec.sample_index = rel[4];
				rec.axis_x = byte_window[63:43];
				rec.axis_y = byte_window[42:22];
				rec.axis_z = byte_window[21:1];
				found.push_back(rec);
			end
		end else if (p == POS_MAG) begin
			rec = '0;
			rec.record_kind = KIND_MAG;
			rec.axis_x = $signed(le16(byte_window, 4));
			rec.axis_y = $signed(le16(byte_window, 2));
			rec.axis_z = $signed(le16(byte_window, 0));
			found.push_back(rec);
		end
		if (eop) begin
			rec = '0;
			rec.record_kind = KIND_END;
			rec.length_ok = (p < POS_MAX) && (p == POS_LEN_A || p == POS_LEN_B);
			found.push_back(rec);
			byte_idx = '0;
		end else begin
			byte_idx = (p < POS_MAX) ? p + 7'd1 : POS_MAX;
		end
		if (found.size() > 0)
			found[found.size() - 1].last = 1'b1;
		foreach (found[i])
			due_records.push_back(found[i]);
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %h actual %h", $time, name, want, got);
			fail_count++;
		end
	endtask

	task automatic compare_record(input rec_t want);
		check_field("record_kind", 32'(want.record_kind), 32'(m_tuser));
		check_field("sample_index", 32'(want.sample_index), 32'(m_tdata[0]));
		check_field("axis_x", 32'($unsigned(want.axis_x)), 32'(m_tdata[21:1]));
		check_field("axis_y", 32'($unsigned(want.axis_y)), 32'(m_tdata[42:22]));
		check_field("axis_z", 32'($unsigned(want.axis_z)), 32'(m_tdata[63:43]));
		check_field("last_cmd", 32'(want.last_cmd), 32'(m_tdata[79:64]));
		check_field("sample_count", 32'(want.sample_count), 32'(m_tdata[81:80]));
		check_field("temperature", 32'($unsigned(want.temperature)), 32'(m_tdata[97:82]));
		check_field("timestamp", want.timestamp, m_tdata[129:98]);
		check_field("length_ok", 32'(want.length_ok), 32'(m_tdata[130]));
		check_field("last", 32'(want.last), 32'(m_tlast));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_idx = '0;
			byte_window = '0;
			cmd_id_hold = '0;
			count_hold = '0;
			temp_hold = '0;
			due_records.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				if (due_records.size() == 0) begin
					$display("%0t: unexpected record, kind expected none actual %0d",
						$time, m_tuser);
					fail_count++;
				end else begin
					compare_record(due_records.pop_front());
					records_checked++;
					if (m_tuser == KIND_END && m_tdata[130])
						good_packets++;
				end
			end
			if (s_tvalid && s_tready)
				parse_byte(s_tdata, s_tlast);
		end
		outstanding = due_records.size();
	end

endmodule

// ===== tb/tracker_sensor_packet_parser_tb.sv =====
// testbench top for the tracker sensor packet parser: byte stimulus and verdict
`timescale 1ns / 1ps

module tracker_sensor_packet_parser_tb;
	import tssp_pkg::*;

	localparam int RANDOM_BYTES = 60;
	localparam int QUIET_LIMIT = 2000;
	localparam int COUNT_FROM_FILL = -1;

	typedef enum {FILL_RANDOM, FILL_ONES, FILL_ZEROS} fill_t;

	typedef struct packed {
		logic [7:0] value;
		logic       eop;
	} raw_byte_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [7:0]         s_tdata = 8'h00;
	logic               s_tlast = 1'b0;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [TDATA_W-1:0] m_tdata;
	logic [2:0]         m_tuser;
	logic               m_tlast;

	int fail_count;
	int outstanding;
	int records_checked;
	int good_packets;

	raw_byte_t report_bytes[$];
	int        packets;
	int        directed_n;
	int        sent;
	int        quiet_cycles;
	int        calm_lo;
	int        calm_hi;

	tracker_sensor_packet_parser i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	tracker_sensor_packet_parser_checker i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tlast         (s_tlast),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.m_tuser         (m_tuser),
		.m_tlast         (m_tlast),
		.fail_count      (fail_count),
		.outstanding     (outstanding),
		.records_checked (records_checked),
		.good_packets    (good_packets)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 0;
	end

	function automatic int idle_pct();
		return (sent >= calm_lo && sent < calm_hi) ? 0 : 31;
	endfunction

	task automatic add_packet(input int len, input int count_byte, input fill_t fill);
		logic [7:0] v;
		for (int i = 0; i < len; i++) begin
			case (fill)
				FILL_ONES:  v = 8'hFF;
				FILL_ZEROS: v = 8'h00;
				default:    v = 8'($urandom);
			endcase
			if (i == POS_COUNT && count_byte != COUNT_FROM_FILL)
				v = 8'(count_byte);
			report_bytes.push_back('{value: v, eop: (i == len - 1)});
		end
		packets++;
	endtask

	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= idle_pct());

	// no transaction on either side for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: timeout, %0d records still expected", $time, outstanding);
				$display("tracker_sensor_packet_parser: mismatch");
				$finish;
			end
		end
	end

	initial begin
		int  pick;
		int  cnt;
		logic accepted;

		// directed packets
		add_packet(62, COUNT_FROM_FILL, FILL_ONES);
		add_packet(64, 1, FILL_ZEROS);
		add_packet(62, 0, FILL_RANDOM);
		add_packet(1, COUNT_FROM_FILL, FILL_RANDOM);
		add_packet(12, 2, FILL_RANDOM);
		add_packet(20, 2, FILL_RANDOM);
		add_packet(44, 2, FILL_RANDOM);
		add_packet(50, 2, FILL_RANDOM);
		add_packet(130, 2, FILL_RANDOM);
		directed_n = report_bytes.size();

		// random packets, mostly well formed
		while (report_bytes.size() < directed_n + RANDOM_BYTES) begin
			pick = $urandom_range(99);
			cnt = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(3);
			if (pick < 70)
				add_packet($urandom_range(1) ? 62 : 64, cnt, FILL_RANDOM);
			else if (pick < 90)
				add_packet($urandom_range(61, 1), cnt, FILL_RANDOM);
			else
				add_packet($urandom_range(140, 63), cnt, FILL_RANDOM);
		end
		calm_lo = report_bytes.size() / 4;
		calm_hi = calm_lo + 200;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		while (sent < report_bytes.size()) begin
			@(posedge clk);
			accepted = s_tvalid && s_tready;
			if (accepted)
				sent++;
			if (!s_tvalid || accepted) begin
				if (sent < report_bytes.size() && $urandom_range(99) >= idle_pct()) begin
					s_tvalid <= 1'b1;
					s_tdata <= report_bytes[sent].value;
					s_tlast <= report_bytes[sent].eop;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end

		do
			@(negedge clk);
		while (outstanding != 0);
		repeat (10) @(posedge clk);

		$display("sent %0d bytes in %0d packets (%0d directed bytes)", sent, packets,
			directed_n);
		$display("checked %0d records, %0d packets reported with a valid length",
			records_checked, good_packets);
		if (fail_count == 0)
			$display("tracker_sensor_packet_parser: match");
		else
			$display("tracker_sensor_packet_parser: mismatch");
		$finish;
	end

endmodule
